FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the RMC sentence parser.
// No dependencies; the NO_ASSERTIONS define strips every assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define NRMC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define NRMC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define NRMC_ASSERT(lbl, clk, rst, prop)
`define NRMC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/nrmc_pkg.sv
// Types and constants for the NMEA RMC checksum and time parser.
// Used by nrmc_parse and the top level; no dependencies.
package nrmc_pkg;

   localparam int MAX_FIELDS = 50;
   localparam int MAX_LINE   = 200;

   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_VOID  = 8'h56;

   localparam logic [4:0] ZONE_RESET = 5'd8;
   localparam logic [7:0] HOURS_WRAP = 8'd24;

   typedef enum logic [2:0] {
      VERDICT_OK         = 3'd0,
      VERDICT_BAD_FRAME  = 3'd1,
      VERDICT_NOT_RMC    = 3'd2,
      VERDICT_VOID       = 3'd3,
      VERDICT_SHORT_TIME = 3'd4
   } verdict_type;

   typedef struct packed {
      logic [6:0]  seconds;
      logic [6:0]  minutes;
      logic [4:0]  local_hours;
      verdict_type verdict;
   } result_type;

   // Expected text of the first field, one character per position.
   function automatic logic [7:0] type_text(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h24;  // '$'
         3'd1:    ch = 8'h47;  // 'G'
         3'd2:    ch = 8'h50;  // 'P'
         3'd3:    ch = 8'h52;  // 'R'
         3'd4:    ch = 8'h4D;  // 'M'
         3'd5:    ch = 8'h43;  // 'C'
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: rtl/nrmc_parse.sv
// Per-character parse state and end-of-sentence verdict logic.
// Depends on nrmc_pkg; the state advances only when step is high.
module nrmc_parse
   import nrmc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] char_in,
   input  logic       last_in,
   input  logic [4:0] zone_offset,
   output result_type result
);

   typedef struct packed {
      logic [7:0]      char_position;
      logic [5:0]      field_number;
      logic [7:0]      char_in_field;
      logic [7:0]      running_xor;
      logic            after_star;
      logic [7:0]      given_checksum;
      logic [1:0]      hex_digit_count;
      logic            type_matches;
      logic            status_void;
      logic [5:0][3:0] time_digits;
      logic            malformed;
      logic            time_complete;
   } parse_type;

   localparam parse_type PARSE_CLEAR = '{
      char_position:   8'd0,
      field_number:    6'd0,
      char_in_field:   8'd0,
      running_xor:     8'd0,
      after_star:      1'b0,
      given_checksum:  8'd0,
      hex_digit_count: 2'd0,
      type_matches:    1'b1,
      status_void:     1'b0,
      time_digits:     '0,
      malformed:       1'b0,
      time_complete:   1'b0
   };

   localparam logic [5:0] LAST_FIELD = 6'(MAX_FIELDS - 1);
   localparam logic [7:0] LINE_LIMIT = 8'(MAX_LINE - 1);

   parse_type state_ff;
   parse_type state_in;

   // Returns the nibble value in the low bits and a valid flag on top.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      if (c inside {[8'h30:8'h39]}) begin
         v = {1'b1, c[3:0]};
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         v = {1'b1, c[3:0] + 4'd9};
      end else begin
         v = 5'd0;
      end
      return v;
   endfunction

   function automatic parse_type close_field(input parse_type s);
      parse_type r;
      r = s;
      if (s.field_number == 6'd0 && s.char_in_field != 8'd6) begin
         r.type_matches = 1'b0;
      end
      if (s.field_number == 6'd1 && s.char_in_field >= 8'd6) begin
         r.time_complete = 1'b1;
      end
      if (s.field_number < LAST_FIELD) begin
         r.field_number  = s.field_number + 6'd1;
         r.char_in_field = 8'd0;
      end
      return r;
   endfunction

   function automatic parse_type field_char(input parse_type s, input logic [7:0] c);
      parse_type r;
      r = s;
      if (s.field_number == 6'd0) begin
         if (s.char_in_field >= 8'd6 || type_text(s.char_in_field[2:0]) != c) begin
            r.type_matches = 1'b0;
         end
      end else if (s.field_number == 6'd1) begin
         if (s.char_in_field < 8'd6) begin
            if (c inside {[8'h30:8'h39]}) begin
               r.time_digits[s.char_in_field[2:0]] = c[3:0];
            end else begin
               r.malformed = 1'b1;
            end
         end
      end else if (s.field_number == 6'd2) begin
         r.status_void = (s.char_in_field == 8'd0) && (c == CHAR_VOID);
      end
      if (s.char_in_field != 8'd255) begin
         r.char_in_field = s.char_in_field + 8'd1;
      end
      return r;
   endfunction

   function automatic logic [6:0] two_digits(input logic [3:0] tens, input logic [3:0] ones);
      return ({3'd0, tens} << 3) + ({3'd0, tens} << 1) + {3'd0, ones};
   endfunction

   parse_type  s;
   parse_type  s_end;
   logic [4:0] hex;
   logic [7:0] hour_sum;

   always_comb begin
      s        = state_ff;
      hex      = hex_value(char_in);
      hour_sum = 8'd0;
      result   = '{seconds: 7'd0, minutes: 7'd0, local_hours: 5'd0,
                   verdict: VERDICT_BAD_FRAME};

      if (state_ff.char_position >= LINE_LIMIT) begin
         s.malformed = 1'b1;
      end

      if (state_ff.after_star) begin
         if (!hex[4] || state_ff.hex_digit_count == 2'd2) begin
            s.malformed = 1'b1;
         end else begin
            s.given_checksum  = {state_ff.given_checksum[3:0], hex[3:0]};
            s.hex_digit_count = state_ff.hex_digit_count + 2'd1;
         end
      end else if (state_ff.char_position == 8'd0) begin
         // The leading character only takes part in the type comparison.
         s = field_char(s, char_in);
      end else if (char_in == CHAR_STAR) begin
         s.after_star = 1'b1;
         s = close_field(s);
      end else begin
         s.running_xor = state_ff.running_xor ^ char_in;
         if (char_in == CHAR_COMMA) begin
            s = close_field(s);
         end else begin
            s = field_char(s, char_in);
         end
      end

      if (state_ff.char_position != 8'd255) begin
         s.char_position = state_ff.char_position + 8'd1;
      end

      // The end of the sentence also closes a field that is still open.
      s_end = s;
      if (!s_end.after_star) begin
         s_end = close_field(s_end);
      end

      if (s_end.malformed || !s_end.after_star || s_end.hex_digit_count != 2'd2 ||
          s_end.running_xor != s_end.given_checksum) begin
         result.verdict = VERDICT_BAD_FRAME;
      end else if (s_end.status_void) begin
         result.verdict = VERDICT_VOID;
      end else if (!s_end.type_matches) begin
         result.verdict = VERDICT_NOT_RMC;
      end else if (!s_end.time_complete) begin
         result.verdict = VERDICT_SHORT_TIME;
      end else begin
         result.verdict = VERDICT_OK;
         // Sum is at most 130, so three conditional subtracts reduce it mod 24.
         hour_sum = {1'b0, two_digits(s_end.time_digits[0], s_end.time_digits[1])}
                  + {3'd0, zone_offset};
         if (hour_sum >= 8'd96) hour_sum = hour_sum - 8'd96;
         if (hour_sum >= 8'd48) hour_sum = hour_sum - 8'd48;
         if (hour_sum >= HOURS_WRAP) hour_sum = hour_sum - HOURS_WRAP;
         result.local_hours = hour_sum[4:0];
         result.minutes     = two_digits(s_end.time_digits[2], s_end.time_digits[3]);
         result.seconds     = two_digits(s_end.time_digits[4], s_end.time_digits[5]);
      end

      state_in = last_in ? PARSE_CLEAR : s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PARSE_CLEAR;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/nmea_rmc_checksum_time_parser_unit.sv
// A result appears on rsp_tvalid once the last character has passed the character and result registers.
// Throughput: one character per cycle; the character register feeds the parse logic
// and the result register in a single pass, so a new request is taken every cycle unless a last character is held.
// A finished result waiting on rsp_tready stalls only end-of-sentence characters.
// Reset (synchronous, active high) clears the parse state, empties both
// registers and sets the zone offset to 8 hours.
`include "assert_macros.svh"

module nmea_rmc_checksum_time_parser_unit
   import nrmc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] sentence_char
   input  logic        req_tlast,   // sentence_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [2:0] verdict, [7:3] local_hours,
                                    // [14:8] minutes, [21:15] seconds, rest zero
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata    // zone_offset_hours
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_last_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   result_type result;
   logic [4:0] zone_ff;
   logic       step;
   logic       req_take;

   // A middle character needs no room at the output; a last one does.
   assign step       = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (step && in_last_ff) ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   nrmc_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .char_in     (in_char_ff),
      .last_in     (in_last_ff),
      .zone_offset (zone_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         zone_ff      <= ZONE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            zone_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (step && in_last_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

   `NRMC_ASSERT(a_rsp_from_last, clock, reset, $rose(rsp_valid_ff) |-> $past(step && in_last_ff))
   `NRMC_ASSERT(a_reject_no_time, clock, reset, (rsp_valid_ff && rsp_data_ff.verdict != VERDICT_OK) |-> (rsp_data_ff.local_hours == 5'd0 && rsp_data_ff.minutes == 7'd0 && rsp_data_ff.seconds == 7'd0))
   `NRMC_ASSERT(a_hours_wrapped, clock, reset, rsp_valid_ff |-> (rsp_data_ff.local_hours < 5'd24))
   `NRMC_ASSERT(a_in_reg_held, clock, reset, (in_valid_ff && !step) |=> (in_valid_ff && $stable(in_char_ff) && $stable(in_last_ff)))

endmodule
